// ===== src/lookahead_path_steering_control_unit_defines.svh =====
// Assertion macros for the lookahead path steering control unit.
// Included by modules that check their own control logic; no other dependencies.
`ifndef LOOKAHEAD_PATH_STEERING_CONTROL_UNIT_DEFINES_SVH
`define LOOKAHEAD_PATH_STEERING_CONTROL_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequence violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/lpsc_pkg.sv =====
// Shared types, constants and the arctangent table of the steering unit.
// No dependencies; used by the CORDIC, square root and top-level modules.
`timescale 1ns / 1ps
package lpsc_pkg;

   localparam int CSR_AW = 5;

   typedef enum logic [2:0] {
      REG_TURN_THRESH,
      REG_TURN_RATE_LIMIT,
      REG_YAW_GAIN,
      REG_YAW_RATE_LIMIT,
      REG_SPEED_LIMIT,
      REG_SPEED_REG_ON,
      REG_HEADING_SPEED_GAIN,
      REG_STOP_DISTANCE
   } reg_idx_type;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_APPEND,
      CMD_ODOM
   } cmd_type;

   localparam int SMALL_W  = 12;
   localparam int D2_W     = 21;
   localparam int CORDIC_W = 32;
   localparam int ANG_W    = 21;
   localparam int E_W      = 22;
   localparam int SQ_IN_W  = 37;
   localparam int SQ_W     = 19;
   localparam int SQ_STEPS = 19;

   localparam int LOOK_UNITS = 1280;
   localparam int LOOK_SQ    = 1638400;
   localparam int SLOW_SQ    = 589824;
   localparam int PI_Q16     = 205887;
   localparam int TWO_PI_Q16 = 411775;
   localparam int RECIP3     = 43691;

   localparam logic [14:0] RST_TURN_THRESH        = 15'd8192;
   localparam logic [14:0] RST_TURN_RATE_LIMIT    = 15'd4096;
   localparam logic [15:0] RST_YAW_GAIN           = 16'd256;
   localparam logic [14:0] RST_YAW_RATE_LIMIT     = 15'd4096;
   localparam logic [14:0] RST_SPEED_LIMIT        = 15'd4096;
   localparam logic        RST_SPEED_REG_ON       = 1'b0;
   localparam logic [15:0] RST_HEADING_SPEED_GAIN = 16'd256;
   localparam logic [19:0] RST_STOP_DISTANCE      = 20'd256;

   function automatic logic signed [ANG_W-1:0] atan_q16(input logic [3:0] i);
      logic signed [ANG_W-1:0] v;
      case (i)
         4'd0: v = 21'sd51472;
         4'd1: v = 21'sd30386;
         4'd2: v = 21'sd16055;
         4'd3: v = 21'sd8150;
         4'd4: v = 21'sd4091;
         4'd5: v = 21'sd2047;
         4'd6: v = 21'sd1024;
         4'd7: v = 21'sd512;
         4'd8: v = 21'sd256;
         4'd9: v = 21'sd128;
         4'd10: v = 21'sd64;
         4'd11: v = 21'sd32;
         4'd12: v = 21'sd16;
         4'd13: v = 21'sd8;
         4'd14: v = 21'sd4;
         default: v = 21'sd2;
      endcase
      return v;
   endfunction

endpackage

// ===== src/lpsc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the stored path points.
`timescale 1ns / 1ps
module lpsc_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/lpsc_cordic.sv =====
// Iterative vectoring CORDIC giving the bearing of a short offset, one step a cycle.
// Depends on lpsc_pkg for widths, pi and the arctangent table.
`timescale 1ns / 1ps
module lpsc_cordic (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [lpsc_pkg::SMALL_W-1:0]  dx,
   input  logic signed [lpsc_pkg::SMALL_W-1:0]  dy,
   output logic                                 busy,
   output logic signed [lpsc_pkg::ANG_W-1:0]    angle
);
   import lpsc_pkg::*;

   localparam logic signed [ANG_W-1:0] PI_A = ANG_W'(PI_Q16);

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys, x0, y0;
   logic signed [ANG_W-1:0]    z_ff, z_in;
   logic [3:0]                 it_ff, it_in;
   logic                       busy_ff, busy_in, zero_ff, zero_in;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      it_in   = it_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      xs      = x_ff >>> it_ff;
      ys      = y_ff >>> it_ff;
      x0      = {{(CORDIC_W-SMALL_W-16){dx[SMALL_W-1]}}, dx, 16'b0};
      y0      = {{(CORDIC_W-SMALL_W-16){dy[SMALL_W-1]}}, dy, 16'b0};
      if (start) begin
         zero_in = (dx == '0) && (dy == '0);
         it_in   = '0;
         busy_in = 1'b1;
         if (dx < 0) begin
            x_in = -x0;
            y_in = -y0;
            z_in = (dy >= 0) ? PI_A : -PI_A;
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_q16(it_ff);
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_q16(it_ff);
         end
         it_in = it_ff + 4'd1;
         if (it_ff == 4'd15) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         it_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         it_ff   <= it_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
   end

   assign busy  = busy_ff;
   assign angle = zero_ff ? '0 : z_ff;
endmodule

// ===== src/lpsc_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on lpsc_pkg for operand widths and step count.
`timescale 1ns / 1ps
module lpsc_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lpsc_pkg::SQ_IN_W-1:0]  value,
   output logic                          busy,
   output logic [lpsc_pkg::SQ_W-1:0]     root
);
   import lpsc_pkg::*;

   logic [SQ_IN_W:0] v_ff, v_in, r_ff, r_in, bitv, t;
   logic [4:0]       k_ff, k_in;
   logic             busy_ff, busy_in;

   always_comb begin
      v_in    = v_ff;
      r_in    = r_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      bitv    = (SQ_IN_W+1)'(1) << {k_ff, 1'b0};
      t       = r_ff + bitv;
      if (start) begin
         v_in    = {1'b0, value};
         r_in    = '0;
         k_in    = 5'(SQ_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= t) begin
            v_in = v_ff - t;
            r_in = (r_ff >> 1) + bitv;
         end else begin
            r_in = r_ff >> 1;
         end
         if (k_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            k_in = k_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
      v_ff <= v_in;
      r_ff <= r_in;
   end

   assign busy = busy_ff;
   assign root = r_ff[SQ_W-1:0];
endmodule

// ===== src/lookahead_path_steering_control_unit.sv =====
// Lookahead path steering control unit: path RAM, scan, bearing and command math.
// Clear and append stay in idle. An odometry transaction scans the stored points
// from the newest back through the RAM read port (one point a cycle) and takes the first
// within the lookahead radius; on a hit the CORDIC and 19-step square root run before
// the command math, and an empty path skips the scan. Reset clears the point count,
// lookahead point, turn flag and registers; the path RAM is not cleared.
`timescale 1ns / 1ps
`include "lookahead_path_steering_control_unit_defines.svh"
module lookahead_path_steering_control_unit #(
   parameter int PATH_DEPTH = 1024,
   parameter int COORD_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic signed [COORD_BITS-1:0]  req_pos_x,
   input  logic signed [COORD_BITS-1:0]  req_pos_y,
   input  logic signed [COORD_BITS-1:0]  req_pos_z,
   input  logic signed [15:0]            req_heading,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [14:0]                   rsp_forward_speed,
   output logic signed [15:0]            rsp_yaw_rate,
   output logic                          rsp_turning_in_place,
   output logic                          rsp_have_lookahead,
   output logic signed [COORD_BITS-1:0]  rsp_target_x,
   output logic signed [COORD_BITS-1:0]  rsp_target_y,
   output logic signed [COORD_BITS-1:0]  rsp_target_z,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lpsc_pkg::CSR_AW-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import lpsc_pkg::*;

   localparam int AW = $clog2(PATH_DEPTH);
   localparam int CW = $clog2(PATH_DEPTH + 1);
   localparam int CB = COORD_BITS;
   localparam int DW = COORD_BITS + 1;
   localparam int RW = 3 * COORD_BITS;
   localparam logic signed [DW-1:0]  LOOK_P  = DW'(LOOK_UNITS);
   localparam logic signed [DW-1:0]  LOOK_N  = -LOOK_P;
   localparam logic signed [E_W-1:0] PI_E    = E_W'(PI_Q16);
   localparam logic signed [E_W-1:0] TWOPI_E = E_W'(TWO_PI_Q16);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_SOLVE, ST_ERR, ST_MUL1, ST_MUL2, ST_FIN
   } state_type;

   // configuration registers
   logic [14:0] turn_thresh_ff, turn_rate_limit_ff, yaw_rate_limit_ff, speed_limit_ff;
   logic [15:0] yaw_gain_ff, heading_speed_gain_ff;
   logic        speed_reg_on_ff;
   logic [19:0] stop_distance_ff;
   logic        csr_wr;

   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_thresh_ff        <= RST_TURN_THRESH;
         turn_rate_limit_ff    <= RST_TURN_RATE_LIMIT;
         yaw_gain_ff           <= RST_YAW_GAIN;
         yaw_rate_limit_ff     <= RST_YAW_RATE_LIMIT;
         speed_limit_ff        <= RST_SPEED_LIMIT;
         speed_reg_on_ff       <= RST_SPEED_REG_ON;
         heading_speed_gain_ff <= RST_HEADING_SPEED_GAIN;
         stop_distance_ff      <= RST_STOP_DISTANCE;
      end else if (csr_wr) begin
         case (reg_idx_type'(paddr[4:2]))
            REG_TURN_THRESH:        turn_thresh_ff        <= pwdata[14:0];
            REG_TURN_RATE_LIMIT:    turn_rate_limit_ff    <= pwdata[14:0];
            REG_YAW_GAIN:           yaw_gain_ff           <= pwdata[15:0];
            REG_YAW_RATE_LIMIT:     yaw_rate_limit_ff     <= pwdata[14:0];
            REG_SPEED_LIMIT:        speed_limit_ff        <= pwdata[14:0];
            REG_SPEED_REG_ON:       speed_reg_on_ff       <= pwdata[0];
            REG_HEADING_SPEED_GAIN: heading_speed_gain_ff <= pwdata[15:0];
            REG_STOP_DISTANCE:      stop_distance_ff      <= pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx_type'(paddr[4:2]))
         REG_TURN_THRESH:        prdata = 32'(turn_thresh_ff);
         REG_TURN_RATE_LIMIT:    prdata = 32'(turn_rate_limit_ff);
         REG_YAW_GAIN:           prdata = 32'(yaw_gain_ff);
         REG_YAW_RATE_LIMIT:     prdata = 32'(yaw_rate_limit_ff);
         REG_SPEED_LIMIT:        prdata = 32'(speed_limit_ff);
         REG_SPEED_REG_ON:       prdata = 32'(speed_reg_on_ff);
         REG_HEADING_SPEED_GAIN: prdata = 32'(heading_speed_gain_ff);
         REG_STOP_DISTANCE:      prdata = 32'(stop_distance_ff);
         default:                prdata = '0;
      endcase
   end

   // control and datapath registers
   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in, rem_ff, rem_in, rd_addr_full;
   logic                     s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   logic [RW-1:0]            pt_ff, rd_data;
   logic signed [DW-1:0]     diff_x_ff, diff_y_ff, diff_z_ff;
   logic signed [DW-1:0]     diff_x_in, diff_y_in, diff_z_in;
   logic signed [CB-1:0]     pos_x_ff, pos_y_ff, pos_z_ff, pos_x_in, pos_y_in, pos_z_in;
   logic signed [15:0]       hd_ff, hd_in;
   logic signed [CB-1:0]     look_x_ff, look_y_ff, look_z_ff, look_x_in, look_y_in, look_z_in;
   logic [D2_W-1:0]          d2_ff, d2_in;
   logic                     found_ff, found_in, turn_ff, turn_in;
   logic signed [18:0]       err_ff, err_in;
   logic [18:0]              aerr_ff, aerr_in;
   logic signed [35:0]       yprod_ff, yprod_in;
   logic [33:0]              sprod_ff, sprod_in;
   logic [34:0]              rprod_ff, rprod_in;
   logic [39:0]              sd2_ff, sd2_in;
   logic signed [15:0]       yaw_ff, yaw_in;
   logic                     tflag_ff, tflag_in, stop_ff, stop_in;
   logic [32:0]              q3_ff, q3_in;
   logic [25:0]              red_ff, red_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [14:0]              rsp_speed_ff, rsp_speed_in;
   logic signed [15:0]       rsp_yaw_ff, rsp_yaw_in;
   logic                     rsp_turn_ff, rsp_turn_in, rsp_have_ff, rsp_have_in;
   logic signed [CB-1:0]     rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_x_in, rsp_y_in, rsp_z_in;

   // scan datapath
   logic signed [CB-1:0]        rd_x, rd_y, rd_z, pt_x, pt_y, pt_z;
   logic signed [SMALL_W-1:0]   sdx, sdy, sdz;
   logic signed [2*SMALL_W:0]   sq_sum;
   logic                        near, hit, issue, miss_done, wr_en;
   logic                        cor_busy, sq_busy;
   logic signed [ANG_W-1:0]     angle;
   logic [SQ_W-1:0]             root;

   assign rd_x = rd_data[RW-1 -: CB];
   assign rd_y = rd_data[2*CB-1 -: CB];
   assign rd_z = rd_data[CB-1:0];
   assign pt_x = pt_ff[RW-1 -: CB];
   assign pt_y = pt_ff[2*CB-1 -: CB];
   assign pt_z = pt_ff[CB-1:0];
   assign sdx  = diff_x_ff[SMALL_W-1:0];
   assign sdy  = diff_y_ff[SMALL_W-1:0];
   assign sdz  = diff_z_ff[SMALL_W-1:0];

   always_comb begin
      near = (diff_x_ff <= LOOK_P) && (diff_x_ff >= LOOK_N)
          && (diff_y_ff <= LOOK_P) && (diff_y_ff >= LOOK_N)
          && (diff_z_ff <= LOOK_P) && (diff_z_ff >= LOOK_N);
      sq_sum = (2*SMALL_W+1)'(sdx * sdx) + (2*SMALL_W+1)'(sdy * sdy)
             + (2*SMALL_W+1)'(sdz * sdz);
   end

   assign hit       = (state_ff == ST_SCAN) && s2_v_ff && near
                   && (sq_sum <= (2*SMALL_W+1)'(LOOK_SQ));
   assign issue     = (state_ff == ST_SCAN) && (rem_ff != '0) && !hit;
   assign miss_done = (state_ff == ST_SCAN) && !hit && (rem_ff == '0) && !s1_v_ff;
   assign rd_addr_full = rem_ff - CW'(1);
   assign req_stall = (state_ff != ST_IDLE);
   assign wr_en     = (state_ff == ST_IDLE) && req_valid && (req_cmd == CMD_APPEND)
                   && (count_ff < CW'(PATH_DEPTH));

   lpsc_ram #(
      .WIDTH (RW),
      .DEPTH (PATH_DEPTH)
   ) u_path_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_pos_x, req_pos_y, req_pos_z}),
      .rd_addr (rd_addr_full[AW-1:0]),
      .rd_data (rd_data)
   );

   lpsc_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (hit),
      .dx    (sdx),
      .dy    (sdy),
      .busy  (cor_busy),
      .angle (angle)
   );

   lpsc_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (hit),
      .value ({sq_sum[D2_W-1:0], 16'b0}),
      .busy  (sq_busy),
      .root  (root)
   );

   // command math
   logic signed [E_W-1:0] e0, ew, e4;
   logic signed [26:0]    raw, lim27;
   logic [14:0]           lim, base, spd_reg, spd_out;
   logic [15:0]           s16;
   logic                  tf;

   always_comb begin
      e0 = $signed({angle[ANG_W-1], angle})
         - $signed({{3{hd_ff[15]}}, hd_ff, 3'b000});
      if (e0 > PI_E) begin
         ew = e0 - TWOPI_E;
      end else if (e0 < -PI_E) begin
         ew = e0 + TWOPI_E;
      end else begin
         ew = e0;
      end
      e4 = ew + E_W'(4);

      tf    = (aerr_ff >= 19'(turn_thresh_ff));
      lim   = tf ? turn_rate_limit_ff : yaw_rate_limit_ff;
      lim27 = $signed(27'(lim));
      raw   = $signed(yprod_ff[35:9]);

      s16  = q3_ff[32:17];
      if (d2_ff >= D2_W'(SLOW_SQ)) begin
         base = speed_limit_ff;
      end else if (s16 >= {1'b0, speed_limit_ff}) begin
         base = speed_limit_ff;
      end else begin
         base = s16[14:0];
      end
      if (red_ff >= 26'(base)) begin
         spd_reg = '0;
      end else begin
         spd_reg = base - red_ff[14:0];
      end
      spd_out = speed_reg_on_ff ? spd_reg : base;
      if (tflag_ff || stop_ff) begin
         spd_out = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      s1_v_in      = issue;
      s2_v_in      = s1_v_ff && (state_ff == ST_SCAN) && !hit;
      diff_x_in    = $signed({rd_x[CB-1], rd_x}) - $signed({pos_x_ff[CB-1], pos_x_ff});
      diff_y_in    = $signed({rd_y[CB-1], rd_y}) - $signed({pos_y_ff[CB-1], pos_y_ff});
      diff_z_in    = $signed({rd_z[CB-1], rd_z}) - $signed({pos_z_ff[CB-1], pos_z_ff});
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      hd_in        = hd_ff;
      look_x_in    = look_x_ff;
      look_y_in    = look_y_ff;
      look_z_in    = look_z_ff;
      d2_in        = d2_ff;
      found_in     = found_ff;
      turn_in      = turn_ff;
      err_in       = err_ff;
      aerr_in      = aerr_ff;
      yprod_in     = yprod_ff;
      sprod_in     = sprod_ff;
      rprod_in     = rprod_ff;
      sd2_in       = sd2_ff;
      yaw_in       = yaw_ff;
      tflag_in     = tflag_ff;
      stop_in      = stop_ff;
      q3_in        = q3_ff;
      red_in       = red_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_speed_in = rsp_speed_ff;
      rsp_yaw_in   = rsp_yaw_ff;
      rsp_turn_in  = rsp_turn_ff;
      rsp_have_in  = rsp_have_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      if (issue) begin
         rem_in = rd_addr_full;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pos_x_in = req_pos_x;
               pos_y_in = req_pos_y;
               pos_z_in = req_pos_z;
               hd_in    = req_heading;
               case (cmd_type'(req_cmd))
                  CMD_CLEAR: count_in = '0;
                  CMD_APPEND: begin
                     if (count_ff < CW'(PATH_DEPTH)) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_ODOM: begin
                     found_in = 1'b0;
                     if (count_ff != '0) begin
                        rem_in   = count_ff;
                        state_in = ST_SCAN;
                     end else begin
                        state_in = ST_FIN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               look_x_in = pt_x;
               look_y_in = pt_y;
               look_z_in = pt_z;
               d2_in     = sq_sum[D2_W-1:0];
               found_in  = 1'b1;
               state_in  = ST_SOLVE;
            end else if (miss_done) begin
               state_in = ST_FIN;
            end
         end
         ST_SOLVE: begin
            if (!cor_busy && !sq_busy) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            err_in   = e4[E_W-1:3];
            aerr_in  = e4[E_W-1] ? 19'(-e4[E_W-1:3]) : e4[E_W-1:3];
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            yprod_in = $signed({1'b0, yaw_gain_ff}) * err_ff;
            sprod_in = speed_limit_ff * root;
            rprod_in = heading_speed_gain_ff * aerr_ff;
            sd2_in   = stop_distance_ff * stop_distance_ff;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            tflag_in = tf;
            if (raw >= lim27) begin
               yaw_in = $signed({1'b0, lim});
            end else if (raw <= -lim27) begin
               yaw_in = -$signed({1'b0, lim});
            end else begin
               yaw_in = raw[15:0];
            end
            q3_in    = sprod_ff[32:16] * 16'(RECIP3);
            red_in   = rprod_ff[34:9];
            stop_in  = (40'(d2_ff) <= sd2_ff);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_have_in  = found_ff;
               rsp_x_in     = look_x_ff;
               rsp_y_in     = look_y_ff;
               rsp_z_in     = look_z_ff;
               if (found_ff) begin
                  turn_in      = tflag_ff;
                  rsp_turn_in  = tflag_ff;
                  rsp_speed_in = spd_out;
                  rsp_yaw_in   = stop_ff ? '0 : yaw_ff;
               end else begin
                  rsp_turn_in  = turn_ff;
                  rsp_speed_in = '0;
                  rsp_yaw_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         look_x_ff    <= '0;
         look_y_ff    <= '0;
         look_z_ff    <= '0;
         turn_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         look_x_ff    <= look_x_in;
         look_y_ff    <= look_y_in;
         look_z_ff    <= look_z_in;
         turn_ff      <= turn_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pt_ff        <= rd_data;
      diff_x_ff    <= diff_x_in;
      diff_y_ff    <= diff_y_in;
      diff_z_ff    <= diff_z_in;
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      pos_z_ff     <= pos_z_in;
      hd_ff        <= hd_in;
      d2_ff        <= d2_in;
      err_ff       <= err_in;
      aerr_ff      <= aerr_in;
      yprod_ff     <= yprod_in;
      sprod_ff     <= sprod_in;
      rprod_ff     <= rprod_in;
      sd2_ff       <= sd2_in;
      yaw_ff       <= yaw_in;
      tflag_ff     <= tflag_in;
      stop_ff      <= stop_in;
      q3_ff        <= q3_in;
      red_ff       <= red_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_yaw_ff   <= rsp_yaw_in;
      rsp_turn_ff  <= rsp_turn_in;
      rsp_have_ff  <= rsp_have_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_z_ff     <= rsp_z_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_forward_speed    = rsp_speed_ff;
   assign rsp_yaw_rate         = rsp_yaw_ff;
   assign rsp_turning_in_place = rsp_turn_ff;
   assign rsp_have_lookahead   = rsp_have_ff;
   assign rsp_target_x         = rsp_x_ff;
   assign rsp_target_y         = rsp_y_ff;
   assign rsp_target_z         = rsp_z_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(PATH_DEPTH))
   `ASSERT_ALWAYS(a_rem_bound, clock, reset, (state_ff != ST_SCAN) || (rem_ff <= count_ff))
   `ASSERT_NEXT(a_odom_scan, clock, reset, (state_ff == ST_IDLE) && req_valid && (req_cmd == CMD_ODOM) && (count_ff != '0), state_ff == ST_SCAN)
   `ASSERT_NEXT(a_fin_rsp, clock, reset, (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall), rsp_valid_ff && (state_ff == ST_IDLE))
endmodule

// ===== tb/tb_lookahead_path_steering_control_unit.sv =====
// Self-checking testbench for the lookahead path steering control unit.
// Depends on lpsc_pkg and the unit; predicts every odometry command and checks it.
`timescale 1ns / 1ps
module tb_lookahead_path_steering_control_unit;
   import lpsc_pkg::*;

   localparam int DEPTH = 1024;
   localparam int LONG_PATH = 200;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam longint SLOW_UNITS_SQ = 589824;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [14:0]        speed;
      logic signed [15:0] yaw;
      logic               turn;
      logic               have;
      logic signed [23:0] tx, ty, tz;
   } steer_cmd_type;

   logic clock = 1'b0, reset = 1'b1;
   logic req_valid = 1'b0, req_stall;
   logic [1:0] req_cmd = 2'd0;
   logic signed [23:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [15:0] req_heading = '0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic [14:0] rsp_forward_speed;
   logic signed [15:0] rsp_yaw_rate;
   logic rsp_turning_in_place, rsp_have_lookahead;
   logic signed [23:0] rsp_target_x, rsp_target_y, rsp_target_z;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0, prdata;
   logic pready;

   lookahead_path_steering_control_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic signed [23:0] path_x [DEPTH], path_y [DEPTH], path_z [DEPTH];
   int unsigned point_count = 0;
   logic signed [23:0] look_x = '0, look_y = '0, look_z = '0;
   logic turn_state = 1'b0;
   longint turn_thresh = 8192, turn_rate_limit = 4096, yaw_gain = 256;
   longint yaw_rate_limit = 4096, speed_limit = 4096, speed_reg_on = 0;
   longint heading_speed_gain = 256, stop_distance = 256;

   steer_cmd_type pending_cmds[$];
   int mismatches = 0;
   int send_idle = 0, recv_idle = 0;
   longint cycles = 0;

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint bearing(longint dx, longint dy);
      longint x, y, z, xs, ys;
      longint atans[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};
      if (dx == 0 && dy == 0) return 0;
      x = dx * 65536;
      y = dy * 65536;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? PI_Q16 : -PI_Q16;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += atans[i];
         end else begin
            x -= ys; y += xs; z -= atans[i];
         end
      end
      return z;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v >= hi) return hi;
      if (v <= lo) return lo;
      return v;
   endfunction

   function automatic void predict_steering(logic [1:0] cmd, logic signed [23:0] px,
         logic signed [23:0] py, logic signed [23:0] pz, logic signed [15:0] hd);
      steer_cmd_type r;
      longint dx, dy, dz, d2, e, err, aerr, lim, spd, yaw;
      logic found;
      found = 1'b0;
      spd = 0;
      yaw = 0;
      if (cmd == CMD_CLEAR) begin
         point_count = 0;
         return;
      end
      if (cmd == CMD_APPEND) begin
         if (point_count < DEPTH) begin
            path_x[point_count] = px;
            path_y[point_count] = py;
            path_z[point_count] = pz;
            point_count++;
         end
         return;
      end
      if (cmd != CMD_ODOM) return;
      for (int k = int'(point_count) - 1; k >= 0 && !found; k--) begin
         dx = longint'(path_x[k]) - longint'(px);
         dy = longint'(path_y[k]) - longint'(py);
         dz = longint'(path_z[k]) - longint'(pz);
         if (dx <= LOOK_UNITS && -dx <= LOOK_UNITS && dy <= LOOK_UNITS && -dy <= LOOK_UNITS
             && dz <= LOOK_UNITS && -dz <= LOOK_UNITS && dx*dx + dy*dy + dz*dz <= LOOK_SQ) begin
            look_x = path_x[k];
            look_y = path_y[k];
            look_z = path_z[k];
            found = 1'b1;
         end
      end
      if (found) begin
         dx = longint'(look_x) - longint'(px);
         dy = longint'(look_y) - longint'(py);
         dz = longint'(look_z) - longint'(pz);
         d2 = dx*dx + dy*dy + dz*dz;
         e = bearing(dx, dy) - longint'(hd) * 8;
         if (e > PI_Q16) e -= TWO_PI_Q16;
         else if (e < -PI_Q16) e += TWO_PI_Q16;
         err = (e + 4) >>> 3;
         aerr = (err < 0) ? -err : err;
         if (aerr < turn_thresh) begin
            lim = yaw_rate_limit;
            turn_state = 1'b0;
         end else begin
            lim = turn_rate_limit;
            turn_state = 1'b1;
         end
         yaw = clip((yaw_gain * err) >>> 9, -lim, lim);
         if (!turn_state) begin
            if (d2 >= SLOW_UNITS_SQ) spd = speed_limit;
            else spd = longint'((longint'(speed_limit) * root_floor(d2 << 16)) / 196608);
            spd = clip(spd, 0, speed_limit);
            if (speed_reg_on != 0)
               spd = clip(spd - ((heading_speed_gain * aerr) >>> 9), 0, speed_limit);
         end
         if (d2 <= stop_distance * stop_distance) begin
            spd = 0;
            yaw = 0;
         end
      end
      r.speed = spd[14:0];
      r.yaw = yaw[15:0];
      r.turn = turn_state;
      r.have = found;
      r.tx = look_x;
      r.ty = look_y;
      r.tz = look_z;
      pending_cmds = {pending_cmds, r};
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("lookahead_path_steering_control_unit regression: fail");
         $finish;
      end
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_idle);

   always @(posedge clock) begin
      steer_cmd_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected steering transaction");
         end else begin
            x = pending_cmds.pop_front();
            if (rsp_forward_speed !== x.speed || rsp_yaw_rate !== x.yaw
                || rsp_turning_in_place !== x.turn || rsp_have_lookahead !== x.have
                || rsp_target_x !== x.tx || rsp_target_y !== x.ty || rsp_target_z !== x.tz) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp spd %0d yaw %0d turn %b have %b tgt %0d %0d %0d,",
                           x.speed, x.yaw, x.turn, x.have, x.tx, x.ty, x.tz,
                           " got spd %0d yaw %0d turn %b have %b tgt %0d %0d %0d",
                           rsp_forward_speed, rsp_yaw_rate, rsp_turning_in_place,
                           rsp_have_lookahead, rsp_target_x, rsp_target_y, rsp_target_z);
            end
         end
      end
   end

   task automatic send_item(logic [1:0] cmd, logic signed [23:0] px, logic signed [23:0] py,
         logic signed [23:0] pz, logic signed [15:0] hd);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_heading <= hd;
      do @(posedge clock); while (req_stall);
      predict_steering(cmd, px, py, pz, hd);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(reg_idx_type idx, longint value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_AW'({idx, 2'b00});
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_TURN_THRESH:        turn_thresh = value & 16'h7FFF;
         REG_TURN_RATE_LIMIT:    turn_rate_limit = value & 16'h7FFF;
         REG_YAW_GAIN:           yaw_gain = value & 16'hFFFF;
         REG_YAW_RATE_LIMIT:     yaw_rate_limit = value & 16'h7FFF;
         REG_SPEED_LIMIT:        speed_limit = value & 16'h7FFF;
         REG_SPEED_REG_ON:       speed_reg_on = value & 1;
         REG_HEADING_SPEED_GAIN: heading_speed_gain = value & 16'hFFFF;
         default:                stop_distance = value & 20'hFFFFF;
      endcase
   endtask

   task automatic set_config(longint tt, longint trl, longint yg, longint yrl, longint sl,
         longint sro, longint hsg, longint sd);
      write_reg(REG_TURN_THRESH, tt);
      write_reg(REG_TURN_RATE_LIMIT, trl);
      write_reg(REG_YAW_GAIN, yg);
      write_reg(REG_YAW_RATE_LIMIT, yrl);
      write_reg(REG_SPEED_LIMIT, sl);
      write_reg(REG_SPEED_REG_ON, sro);
      write_reg(REG_HEADING_SPEED_GAIN, hsg);
      write_reg(REG_STOP_DISTANCE, sd);
   endtask

   function automatic logic signed [23:0] near(logic signed [23:0] c, int span);
      return c + 24'($signed($urandom_range(2 * span)) - span);
   endfunction

   function automatic logic signed [15:0] rand_heading();
      return 16'($signed($urandom_range(51472)) - 25736);
   endfunction

   task automatic test_directed();
      send_item(CMD_ODOM, 0, 0, 0, 0);
      send_item(CMD_APPEND, 0, 0, 0, 0);
      send_item(CMD_ODOM, 0, 0, 0, 0);
      send_item(CMD_ODOM, -24'sd500, 0, 0, 25736);
      send_item(CMD_ODOM, 0, -24'sd700, 10, -16'sd25736);
      send_item(CMD_ODOM, -24'sd1280, 0, 0, 0);
      send_item(CMD_ODOM, 24'sd300, 24'sd300, 0, 0);
      send_item(CMD_APPEND, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0);
      send_item(CMD_APPEND, 24'sh800000, 24'sh800000, 24'sh800000, 0);
      send_item(CMD_ODOM, 24'h7FFBFF, 24'h7FFFFF, 24'h7FFFFF, 16'sd100);
      send_item(CMD_ODOM, 24'sh800300, 24'sh800100, 24'sh800000, -16'sd100);
      send_item(CMD_ODOM, 24'sd5000, 0, 0, 0);
      send_item(CMD_UNUSED, 24'sd77, 24'sd88, 24'sd99, 16'sd1);
      send_item(CMD_CLEAR, 0, 0, 0, 0);
      send_item(CMD_ODOM, 0, 0, 0, 0);
      send_item(CMD_APPEND, 24'sd1000, 24'sd1000, 0, 0);
      send_item(CMD_ODOM, 24'sd1000, 24'sd1500, 0, 16'sh7FFF);
      send_item(CMD_ODOM, 24'sd1300, 24'sd900, 0, 16'sh8000);
      send_item(CMD_ODOM, 24'sd1100, 24'sd1000, 24'sd900, 16'sh5555);
      send_item(CMD_ODOM, 24'sd900, 24'sd1000, -24'sd200, 16'shAAAA);
      drain();
   endtask

   task automatic test_long_path();
      send_item(CMD_CLEAR, 0, 0, 0, 0);
      send_item(CMD_APPEND, 24'sd100, 24'sd50, 0, 0);
      for (int i = 1; i < LONG_PATH; i++)
         send_item(CMD_APPEND, 24'(40000 + 16 * i), 24'sd60000, 0, 0);
      send_item(CMD_ODOM, 0, 0, 0, 0);
      send_item(CMD_ODOM, 24'sd40000, 24'sd60000, 0, 0);
      send_item(CMD_ODOM, -24'sd90000, 0, 0, 0);
      send_item(CMD_CLEAR, 0, 0, 0, 0);
      drain();
   endtask

   task automatic test_random(int n);
      logic signed [23:0] bx, by, bz;
      int sent, r;
      sent = 0;
      while (sent < n) begin
         r = $urandom_range(99);
         if (r < 85) begin
            bx = 24'($urandom);
            by = 24'($urandom);
            bz = 24'($urandom);
            if ($urandom_range(3) != 0 || point_count > 40) begin
               send_item(CMD_CLEAR, 24'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
               sent++;
            end
            repeat ($urandom_range(1, 6)) begin
               send_item(CMD_APPEND, near(bx, 1600), near(by, 1600), near(bz, 900), 16'($urandom));
               sent++;
            end
            repeat ($urandom_range(1, 3)) begin
               send_item(CMD_ODOM, near(bx, 1500), near(by, 1500), near(bz, 700),
                         rand_heading());
               sent++;
            end
         end else begin
            send_item(r < 92 ? CMD_UNUSED : CMD_ODOM, 24'($urandom), 24'($urandom),
                      24'($urandom), rand_heading());
            sent++;
         end
      end
      drain();
   endtask

   task automatic test_pause();
      send_item(CMD_APPEND, 24'sd9, 24'sd9, 24'sd9, 0);
      send_item(CMD_ODOM, 24'sd400, 24'sd9, 24'sd9, 0);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0) @(posedge clock);
      send_item(CMD_ODOM, 24'sd9, 24'sd600, 24'sd9, -16'sd3000);
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      set_config(25736, 32767, 65535, 32767, 32767, 1, 65535, 1048575);
      test_directed();
      set_config(0, 0, 0, 0, 0, 0, 0, 0);
      test_directed();
      set_config(6000, 3000, 2000, 8000, 20000, 1, 900, 40);
      test_long_path();
      send_idle = 15;
      recv_idle = 59;
      test_random(90);
      test_pause();
      set_config($urandom_range(25736), $urandom_range(32767), $urandom_range(65535),
                 $urandom_range(32767), $urandom_range(32767), 1, $urandom_range(65535),
                 $urandom_range(300));
      send_idle = 59;
      recv_idle = 15;
      test_random(90);
      set_config(12000, 20000, 512, 10000, 32767, 0, 256, 0);
      send_idle = 0;
      recv_idle = 0;
      test_random(90);
      repeat (1100) @(posedge clock);
      if (mismatches == 0 && pending_cmds.size() == 0) begin
         $display("lookahead_path_steering_control_unit regression: pass");
      end else begin
         $display("lookahead_path_steering_control_unit regression: fail");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+src
src/lpsc_pkg.sv
src/lpsc_ram.sv
src/lpsc_cordic.sv
src/lpsc_sqrt.sv
src/lookahead_path_steering_control_unit.sv
tb/tb_lookahead_path_steering_control_unit.sv
